@@ hdl/wavhp_pkg.sv @@
package wavhp_pkg;

    // Chunk and form identifiers, first character in the top byte.
    localparam logic [31:0] ID_WAVE_UP = 32'h5741_5645;
    localparam logic [31:0] ID_WAVE_LO = 32'h7761_7665;
    localparam logic [31:0] ID_FMT_LO  = 32'h666D_7420;
    localparam logic [31:0] ID_FMT_UP  = 32'h464D_5420;
    localparam logic [31:0] ID_DATA_LO = 32'h6461_7461;
    localparam logic [31:0] ID_DATA_UP = 32'h4441_5441;

    localparam logic [31:0] FMT_BASE_SIZE = 32'd16;
    localparam logic [31:0] PCM_FORMAT    = 32'd1;

    typedef enum logic [2:0] {
        ST_PARSING   = 3'd0,
        ST_DONE      = 3'd1,
        ST_NOT_WAVE  = 3'd2,
        ST_NOT_PCM   = 3'd3,
        ST_EARLY_END = 3'd4
    } status_t;

    typedef enum logic [14:0] {
        PH_RIFF_ID   = 15'b000_0000_0000_0001,
        PH_RIFF_SIZE = 15'b000_0000_0000_0010,
        PH_FORM      = 15'b000_0000_0000_0100,
        PH_FMT_ID    = 15'b000_0000_0000_1000,
        PH_FMT_SIZE  = 15'b000_0000_0001_0000,
        PH_FMT_SKIP  = 15'b000_0000_0010_0000,
        PH_AUDIO_FMT = 15'b000_0000_0100_0000,
        PH_CHANNELS  = 15'b000_0000_1000_0000,
        PH_RATE      = 15'b000_0001_0000_0000,
        PH_BYTE_RATE = 15'b000_0010_0000_0000,
        PH_ALIGN     = 15'b000_0100_0000_0000,
        PH_BITS      = 15'b000_1000_0000_0000,
        PH_DATA_SKIP = 15'b001_0000_0000_0000,
        PH_DATA_ID   = 15'b010_0000_0000_0000,
        PH_DATA_SIZE = 15'b100_0000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } item_t;

    // Number of bytes in the field gathered during a phase.
    function automatic logic [2:0] field_len(input phase_t ph);
        logic [2:0] len;
        begin
            unique case (ph)
                PH_AUDIO_FMT, PH_CHANNELS, PH_ALIGN, PH_BITS: len = 3'd2;
                PH_FMT_SKIP, PH_DATA_SKIP:                    len = 3'd0;
                default:                                      len = 3'd4;
            endcase
            return len;
        end
    endfunction

endpackage

@@ hdl/wav_header_parser_unit.sv @@
// The input register holds a byte until the parser can take it: when no result is held
// or the held one is taken. Throughput: one byte per cycle while results are taken, set
// by the update of the parser state. The input and result registers decouple the two
// sides, so a stalled result still lets one byte into an empty input register.
// Reset (rst_n, asynchronous, active low) empties both stages and clears all fields.
module wav_header_parser_unit
    import wavhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] riff_size,
    output logic [15:0] num_channels,
    output logic [31:0] sample_rate,
    output logic [31:0] byte_rate,
    output logic [15:0] block_align,
    output logic [15:0] bits_per_sample,
    output logic [31:0] data_size,
    output logic [31:0] data_offset
);

    item_t in_item;
    item_t item;
    logic  item_vld;
    logic  item_take;

    assign in_item.data_byte  = data_byte;
    assign in_item.first_byte = first_byte;
    assign in_item.last_byte  = last_byte;

    wavhp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .item_vld  (item_vld),
        .item      (item),
        .item_take (item_take)
    );

    wavhp_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_vld        (item_vld),
        .item            (item),
        .item_take       (item_take),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .riff_size       (riff_size),
        .num_channels    (num_channels),
        .sample_rate     (sample_rate),
        .byte_rate       (byte_rate),
        .block_align     (block_align),
        .bits_per_sample (bits_per_sample),
        .data_size       (data_size),
        .data_offset     (data_offset)
    );

endmodule

@@ hdl/wavhp_in_stage.sv @@
module wavhp_in_stage
    import wavhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  item_t      in_item,
    output logic       item_vld,
    output item_t      item,
    input  logic       item_take
);

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;
    item_t item_next;

    assign in_ready = !vld_reg || item_take;

    always_comb
    begin
        vld_next  = vld_reg;
        item_next = item_reg;
        if (in_ready)
        begin
            vld_next  = in_valid;
            item_next = in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

@@ hdl/wavhp_core.sv @@
module wavhp_core
    import wavhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_vld,
    input  item_t       item,
    output logic        item_take,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] riff_size,
    output logic [15:0] num_channels,
    output logic [31:0] sample_rate,
    output logic [31:0] byte_rate,
    output logic [15:0] block_align,
    output logic [15:0] bits_per_sample,
    output logic [31:0] data_size,
    output logic [31:0] data_offset
);

    logic        out_valid_reg, out_valid_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] skip_reg, skip_next;
    status_t     status_reg, status_next;
    logic [31:0] riff_size_reg, riff_size_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] dsize_reg, dsize_next;
    logic [31:0] doffs_reg, doffs_next;

    // Working copies after an optional restart by first_byte.
    phase_t      cur_phase;
    logic [31:0] cur_pos, cur_shift, cur_id, cur_skip;
    logic [1:0]  cur_cnt;
    status_t     cur_status;
    logic [31:0] gathered;
    logic [2:0]  cnt_inc;
    logic [2:0]  len;
    logic [31:0] id_now;

    assign item_take = item_vld && (!out_valid_reg || out_ready);

    always_comb
    begin
        cur_phase  = item.first_byte ? PH_RIFF_ID : phase_reg;
        cur_pos    = item.first_byte ? 32'd0 : pos_reg;
        cur_cnt    = item.first_byte ? 2'd0 : cnt_reg;
        cur_shift  = item.first_byte ? 32'd0 : shift_reg;
        cur_id     = item.first_byte ? 32'd0 : id_reg;
        cur_skip   = item.first_byte ? 32'd0 : skip_reg;
        cur_status = item.first_byte ? ST_PARSING : status_reg;

        len      = field_len(cur_phase);
        gathered = cur_shift | ({24'd0, item.data_byte} << {cur_cnt, 3'b000});
        cnt_inc  = {1'b0, cur_cnt} + 3'd1;
        id_now   = {cur_id[23:0], item.data_byte};

        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        shift_next     = shift_reg;
        id_next        = id_reg;
        skip_next      = skip_reg;
        status_next    = status_reg;
        riff_size_next = riff_size_reg;
        chan_next      = chan_reg;
        rate_next      = rate_reg;
        brate_next     = brate_reg;
        align_next     = align_reg;
        bits_next      = bits_reg;
        dsize_next     = dsize_reg;
        doffs_next     = doffs_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (item_take)
        begin
            out_valid_next = 1'b1;
            phase_next     = cur_phase;
            pos_next       = cur_pos;
            cnt_next       = cur_cnt;
            shift_next     = cur_shift;
            id_next        = cur_id;
            skip_next      = cur_skip;
            status_next    = cur_status;
            if (item.first_byte)
            begin
                riff_size_next = '0;
                chan_next      = '0;
                rate_next      = '0;
                brate_next     = '0;
                align_next     = '0;
                bits_next      = '0;
                dsize_next     = '0;
                doffs_next     = '0;
            end

            if (cur_status == ST_PARSING)
            begin
                pos_next = cur_pos + 32'd1;
                if (cur_phase == PH_FMT_SKIP || cur_phase == PH_DATA_SKIP)
                begin
                    skip_next = cur_skip - 32'd1;
                    if (cur_skip == 32'd1)
                    begin
                        phase_next = (cur_phase == PH_FMT_SKIP) ? PH_FMT_ID : PH_DATA_ID;
                    end
                end
                else if (len != 3'd0)
                begin
                    if (cur_phase == PH_FORM || cur_phase == PH_FMT_ID ||
                        cur_phase == PH_DATA_ID)
                    begin
                        id_next = id_now;
                    end
                    if (cnt_inc < len)
                    begin
                        shift_next = gathered;
                        cnt_next   = cnt_inc[1:0];
                    end
                    else
                    begin
                        shift_next = '0;
                        cnt_next   = '0;
                        unique case (cur_phase)
                            PH_RIFF_ID:   phase_next = PH_RIFF_SIZE;
                            PH_RIFF_SIZE:
                            begin
                                riff_size_next = gathered;
                                phase_next     = PH_FORM;
                            end
                            PH_FORM:
                            begin
                                if (id_now == ID_WAVE_UP || id_now == ID_WAVE_LO)
                                begin
                                    phase_next = PH_FMT_ID;
                                end
                                else
                                begin
                                    status_next = ST_NOT_WAVE;
                                end
                            end
                            PH_FMT_ID:    phase_next = PH_FMT_SIZE;
                            PH_FMT_SIZE:
                            begin
                                skip_next = gathered;
                                if (cur_id == ID_FMT_LO || cur_id == ID_FMT_UP)
                                begin
                                    phase_next = PH_AUDIO_FMT;
                                end
                                else if (gathered == 32'd0)
                                begin
                                    phase_next = PH_FMT_ID;
                                end
                                else
                                begin
                                    phase_next = PH_FMT_SKIP;
                                end
                            end
                            PH_AUDIO_FMT:
                            begin
                                if (gathered != PCM_FORMAT)
                                begin
                                    status_next = ST_NOT_PCM;
                                end
                                else
                                begin
                                    phase_next = PH_CHANNELS;
                                end
                            end
                            PH_CHANNELS:
                            begin
                                chan_next  = gathered[15:0];
                                phase_next = PH_RATE;
                            end
                            PH_RATE:
                            begin
                                rate_next  = gathered;
                                phase_next = PH_BYTE_RATE;
                            end
                            PH_BYTE_RATE:
                            begin
                                brate_next = gathered;
                                phase_next = PH_ALIGN;
                            end
                            PH_ALIGN:
                            begin
                                align_next = gathered[15:0];
                                phase_next = PH_BITS;
                            end
                            PH_BITS:
                            begin
                                bits_next = gathered[15:0];
                                // Anything in the format chunk past the base fields is skipped.
                                if (cur_skip > FMT_BASE_SIZE)
                                begin
                                    skip_next  = cur_skip - FMT_BASE_SIZE;
                                    phase_next = PH_DATA_SKIP;
                                end
                                else
                                begin
                                    skip_next  = '0;
                                    phase_next = PH_DATA_ID;
                                end
                            end
                            PH_DATA_ID:   phase_next = PH_DATA_SIZE;
                            PH_DATA_SIZE:
                            begin
                                skip_next = gathered;
                                if (cur_id == ID_DATA_LO || cur_id == ID_DATA_UP)
                                begin
                                    skip_next   = cur_skip;
                                    dsize_next  = gathered;
                                    doffs_next  = cur_pos + 32'd1;
                                    status_next = ST_DONE;
                                end
                                else if (gathered == 32'd0)
                                begin
                                    phase_next = PH_DATA_ID;
                                end
                                else
                                begin
                                    phase_next = PH_DATA_SKIP;
                                end
                            end
                            default:
                            begin
                                phase_next = cur_phase;
                            end
                        endcase
                    end
                end
                if (status_next == ST_PARSING && item.last_byte)
                begin
                    status_next = ST_EARLY_END;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_RIFF_ID;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            shift_reg     <= '0;
            id_reg        <= '0;
            skip_reg      <= '0;
            status_reg    <= ST_PARSING;
            riff_size_reg <= '0;
            chan_reg      <= '0;
            rate_reg      <= '0;
            brate_reg     <= '0;
            align_reg     <= '0;
            bits_reg      <= '0;
            dsize_reg     <= '0;
            doffs_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            shift_reg     <= shift_next;
            id_reg        <= id_next;
            skip_reg      <= skip_next;
            status_reg    <= status_next;
            riff_size_reg <= riff_size_next;
            chan_reg      <= chan_next;
            rate_reg      <= rate_next;
            brate_reg     <= brate_next;
            align_reg     <= align_next;
            bits_reg      <= bits_next;
            dsize_reg     <= dsize_next;
            doffs_reg     <= doffs_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign riff_size       = riff_size_reg;
    assign num_channels    = chan_reg;
    assign sample_rate     = rate_reg;
    assign byte_rate       = brate_reg;
    assign block_align     = align_reg;
    assign bits_per_sample = bits_reg;
    assign data_size       = dsize_reg;
    assign data_offset     = doffs_reg;

    // Once parsing has ended, only a restart may change the status.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_take && !item.first_byte && status_reg != ST_PARSING
        |=> status_reg == $past(status_reg))
        else $error("status changed after parsing ended");

    // A skip phase is entered only with bytes left to skip.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FMT_SKIP || phase_reg == PH_DATA_SKIP) |-> skip_reg != 32'd0)
        else $error("skip phase with nothing to skip");

    // Each byte taken while parsing advances the file position by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_take && !item.first_byte && status_reg == ST_PARSING
        |=> pos_reg == $past(pos_reg) + 32'd1)
        else $error("byte position did not advance");

    // No transfer is taken while a result is still held and not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !item_take)
        else $error("result overwritten before transfer");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import wavhp_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          BYTE_TARGET  = 1950;
    localparam int          N_DIRECTED   = 28;
    localparam int          DRAIN_CYCLES = 10;
    localparam logic [31:0] RIFF_ID      = 32'h5249_4646;
    localparam logic [31:0] ID_LIST      = 32'h4C49_5354;
    localparam logic [31:0] ID_JUNK      = 32'h6A75_6E6B;
    localparam logic [31:0] ID_FACT      = 32'h6661_6374;

    // One byte of the stream; typed rows carry a status that is known by inspection.
    typedef struct packed {
        logic [7:0] b;
        logic       first;
        logic       last;
        logic       typed;
        status_t    want;
    } stim_t;

    // Index 0 is the status, then the eight captured fields in port order.
    typedef logic [8:0][31:0] result_t;

    localparam stim_t DIRECTED [N_DIRECTED] = '{
        // "RIFF", size all ones, a bad form id with the last byte flag on it
        '{8'h52, 1'b1, 1'b0, 1'b0, ST_PARSING},
        '{8'h49, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h46, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h46, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h57, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h41, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h56, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h58, 1'b0, 1'b1, 1'b1, ST_NOT_WAVE},
        '{8'h00, 1'b0, 1'b0, 1'b1, ST_NOT_WAVE},
        // A one-byte file, then a byte after its end.
        '{8'h00, 1'b1, 1'b1, 1'b1, ST_EARLY_END},
        '{8'hFF, 1'b0, 1'b1, 1'b1, ST_EARLY_END},
        // "RIFF", size zero, lower-case form, then a restart part way through.
        '{8'h52, 1'b1, 1'b0, 1'b0, ST_PARSING},
        '{8'h49, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h46, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h46, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h77, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h61, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h76, 1'b0, 1'b0, 1'b0, ST_PARSING},
        '{8'h65, 1'b0, 1'b0, 1'b1, ST_PARSING},
        '{8'h00, 1'b1, 1'b0, 1'b1, ST_PARSING}
    };

    logic        clk;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte       = 8'h00;
    logic        first_byte      = 1'b0;
    logic        last_byte       = 1'b0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic [2:0]  status;
    logic [31:0] riff_size;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
    logic [31:0] data_offset;

    stim_t       byte_stream [$];
    logic [7:0]  file_bytes [$];
    result_t     pending_results [$];
    stim_t       on_bus;
    logic        hold_off = 1'b0;
    int          next_idx = 0;
    int          bytes_sent = 0;
    int          results_seen = 0;
    int          files_built = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          status_tally [5] = '{0, 0, 0, 0, 0};
    string       field_name [9] = '{"status", "riff_size", "num_channels", "sample_rate",
                                    "byte_rate", "block_align", "bits_per_sample",
                                    "data_size", "data_offset"};

    // Parser state as seen by the predictor.
    phase_t      hdr_phase;
    status_t     hdr_status;
    logic [31:0] hdr_pos;
    logic [31:0] hdr_acc;
    int          hdr_nacc;
    logic [31:0] hdr_id;
    logic [31:0] hdr_skip;
    logic [31:0] hdr_fields [8];

    wav_header_parser_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .first_byte      (first_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .riff_size       (riff_size),
        .num_channels    (num_channels),
        .sample_rate     (sample_rate),
        .byte_rate       (byte_rate),
        .block_align     (block_align),
        .bits_per_sample (bits_per_sample),
        .data_size       (data_size),
        .data_offset     (data_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic clear_parser();
        hdr_phase  = PH_RIFF_ID;
        hdr_status = ST_PARSING;
        hdr_pos    = '0;
        hdr_acc    = '0;
        hdr_nacc   = 0;
        hdr_id     = '0;
        hdr_skip   = '0;
        foreach (hdr_fields[k])
            hdr_fields[k] = '0;
    endtask

    task automatic begin_skip(input logic [31:0] n, input phase_t skip_ph, input phase_t back_ph);
        hdr_skip  = n;
        hdr_phase = (n == 32'd0) ? back_ph : skip_ph;
    endtask

    // Advances the expected parser by one byte and returns the result that it shows.
    task automatic parse_wav_byte(input logic [7:0] b, input logic first, input logic last,
                                  output result_t r);
        logic [31:0] v;
        int          need;
        if (first)
            clear_parser();
        if (hdr_status == ST_PARSING)
        begin
            if (hdr_phase inside {PH_FMT_SKIP, PH_DATA_SKIP})
            begin
                hdr_skip = hdr_skip - 32'd1;
                if (hdr_skip == 32'd0)
                    hdr_phase = (hdr_phase == PH_FMT_SKIP) ? PH_FMT_ID : PH_DATA_ID;
            end
            else
            begin
                need = (hdr_phase inside {PH_AUDIO_FMT, PH_CHANNELS, PH_ALIGN, PH_BITS}) ? 2 : 4;
                hdr_acc = hdr_acc | (32'(b) << (8 * hdr_nacc));
                hdr_nacc++;
                if (hdr_phase inside {PH_FORM, PH_FMT_ID, PH_DATA_ID})
                    hdr_id = {hdr_id[23:0], b};
                if (hdr_nacc == need)
                begin
                    v        = hdr_acc;
                    hdr_acc  = '0;
                    hdr_nacc = 0;
                    case (hdr_phase)
                        PH_RIFF_ID:   hdr_phase = PH_RIFF_SIZE;
                        PH_RIFF_SIZE:
                        begin
                            hdr_fields[0] = v;
                            hdr_phase     = PH_FORM;
                        end
                        PH_FORM:
                        begin
                            if (hdr_id == ID_WAVE_UP || hdr_id == ID_WAVE_LO)
                                hdr_phase = PH_FMT_ID;
                            else
                                hdr_status = ST_NOT_WAVE;
                        end
                        PH_FMT_ID:    hdr_phase = PH_FMT_SIZE;
                        PH_FMT_SIZE:
                        begin
                            // The fmt size is kept so that any bytes past the fields are skipped.
                            if (hdr_id == ID_FMT_LO || hdr_id == ID_FMT_UP)
                            begin
                                hdr_skip  = v;
                                hdr_phase = PH_AUDIO_FMT;
                            end
                            else
                                begin_skip(v, PH_FMT_SKIP, PH_FMT_ID);
                        end
                        PH_AUDIO_FMT:
                        begin
                            if (v != PCM_FORMAT)
                                hdr_status = ST_NOT_PCM;
                            else
                                hdr_phase = PH_CHANNELS;
                        end
                        PH_CHANNELS:
                        begin
                            hdr_fields[1] = {16'd0, v[15:0]};
                            hdr_phase     = PH_RATE;
                        end
                        PH_RATE:
                        begin
                            hdr_fields[2] = v;
                            hdr_phase     = PH_BYTE_RATE;
                        end
                        PH_BYTE_RATE:
                        begin
                            hdr_fields[3] = v;
                            hdr_phase     = PH_ALIGN;
                        end
                        PH_ALIGN:
                        begin
                            hdr_fields[4] = {16'd0, v[15:0]};
                            hdr_phase     = PH_BITS;
                        end
                        PH_BITS:
                        begin
                            hdr_fields[5] = {16'd0, v[15:0]};
                            begin_skip((hdr_skip > FMT_BASE_SIZE) ?
                                           hdr_skip - FMT_BASE_SIZE : 32'd0,
                                       PH_DATA_SKIP, PH_DATA_ID);
                        end
                        PH_DATA_ID:   hdr_phase = PH_DATA_SIZE;
                        PH_DATA_SIZE:
                        begin
                            if (hdr_id == ID_DATA_LO || hdr_id == ID_DATA_UP)
                            begin
                                hdr_fields[6] = v;
                                hdr_fields[7] = hdr_pos + 32'd1;
                                hdr_status    = ST_DONE;
                            end
                            else
                                begin_skip(v, PH_DATA_SKIP, PH_DATA_ID);
                        end
                        default: ;
                    endcase
                end
            end
            hdr_pos = hdr_pos + 32'd1;
            if (hdr_status == ST_PARSING && last)
                hdr_status = ST_EARLY_END;
        end
        r[0] = 32'(hdr_status);
        for (int k = 0; k < 8; k++)
            r[k + 1] = hdr_fields[k];
    endtask

    task automatic note_failure(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [31:0] pick32();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick16();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'h0000_FFFF;
        return 32'($urandom_range(65535));
    endfunction

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(v[8 * i +: 8]);
    endtask

    task automatic put_id(input logic [31:0] id);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(id[8 * i +: 8]);
    endtask

    task automatic put_noise(input int n);
        repeat (n)
            file_bytes.push_back(8'($urandom));
    endtask

    // A chunk that the parser must step over: empty, short, or too long to finish.
    task automatic put_other_chunk();
        logic [31:0] len;
        int          r;
        r = $urandom_range(99);
        case ($urandom_range(3))
            0:       put_id(ID_LIST);
            1:       put_id(ID_JUNK);
            2:       put_id(ID_FACT);
            default: put_id($urandom);
        endcase
        if (r < 20)
            len = 32'd0;
        else if (r < 23)
            len = $urandom | 32'h0100_0000;
        else
            len = 32'($urandom_range(1, 9));
        put_le(len, 4);
        put_noise((len > 32'd12) ? 12 : int'(len));
    endtask

    task automatic queue_file();
        logic [31:0] fmt_len;
        int          cut;
        int          n;
        logic        ends;
        logic        noisy;
        stim_t       s;
        file_bytes.delete();
        noisy = ($urandom_range(99) < 8);
        if (noisy)
            put_noise($urandom_range(1, 24));
        else
        begin
            put_id(($urandom_range(9) == 0) ? $urandom : RIFF_ID);
            put_le(pick32(), 4);
            case ($urandom_range(15))
                0:             put_id($urandom);
                1, 2, 3, 4, 5: put_id(ID_WAVE_UP);
                default:       put_id(ID_WAVE_LO);
            endcase
            n = $urandom_range(2);
            repeat (n)
                put_other_chunk();
            put_id($urandom_range(1) ? ID_FMT_LO : ID_FMT_UP);
            case ($urandom_range(5))
                0:       fmt_len = 32'd0;
                1:       fmt_len = 32'd14;
                2:       fmt_len = 32'd18;
                3:       fmt_len = 32'($urandom_range(17, 30));
                default: fmt_len = FMT_BASE_SIZE;
            endcase
            put_le(fmt_len, 4);
            put_le(($urandom_range(11) == 0) ? pick16() : PCM_FORMAT, 2);
            put_le(pick16(), 2);
            put_le(pick32(), 4);
            put_le(pick32(), 4);
            put_le(pick16(), 2);
            put_le(pick16(), 2);
            if (fmt_len > FMT_BASE_SIZE)
                put_noise(int'(fmt_len - FMT_BASE_SIZE));
            n = $urandom_range(2);
            repeat (n)
                put_other_chunk();
            put_id($urandom_range(1) ? ID_DATA_LO : ID_DATA_UP);
            put_le(pick32(), 4);
            put_noise($urandom_range(3));
        end
        // Some files are cut short; some end without a last byte and the next may restart them.
        cut = file_bytes.size();
        if ($urandom_range(99) < 15)
            cut = $urandom_range(1, cut);
        ends = ($urandom_range(99) < 75);
        for (int i = 0; i < cut; i++)
        begin
            s.b     = file_bytes[i];
            s.first = (i == 0) && (!noisy || $urandom_range(1) == 1);
            s.last  = (ends && i == cut - 1) || (noisy && $urandom_range(19) == 0);
            s.typed = 1'b0;
            s.want  = ST_PARSING;
            byte_stream.push_back(s);
        end
        files_built++;
    endtask

    // Sender: offers bytes from the stream and predicts the result of each transfer.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                parse_wav_byte(data_byte, first_byte, last_byte, exp_r);
                if (on_bus.typed)
                    exp_r[0] = 32'(on_bus.want);
                pending_results.push_back(exp_r);
                bytes_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (next_idx < byte_stream.size() &&
                    ((next_idx >= 600 && next_idx < 900) || $urandom_range(99) >= 30))
                begin
                    on_bus     <= byte_stream[next_idx];
                    data_byte  <= byte_stream[next_idx].b;
                    first_byte <= byte_stream[next_idx].first;
                    last_byte  <= byte_stream[next_idx].last;
                    in_valid   <= 1'b1;
                    next_idx++;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: compares every result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {data_offset, data_size, 16'd0, bits_per_sample, 16'd0, block_align,
                       byte_rate, sample_rate, 16'd0, num_channels, riff_size, 29'd0, status};
                results_seen++;
                if (got[0] < 32'd5)
                    status_tally[got[0]]++;
                if (pending_results.size() == 0)
                    note_failure($sformatf("result with status %0d arrived unexpectedly",
                                           got[0]));
                else
                begin
                    want = pending_results.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got[k] !== want[k])
                            note_failure($sformatf("result %0d: %s is %h, expected %h",
                                                   results_seen, field_name[k], got[k], want[k]));
                end
            end
            if (hold_off)
                out_ready <= 1'b0;
            else
                out_ready <= (results_seen >= 600 && results_seen < 900) ||
                             ($urandom_range(99) >= 30);
        end
    end

    // A long hold-off on the result side while bytes keep being offered.
    initial
    begin
        wait (results_seen >= 1200);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        clear_parser();
        foreach (DIRECTED[i])
            byte_stream.push_back(DIRECTED[i]);
        while (byte_stream.size() < N_DIRECTED + BYTE_TARGET)
            queue_file();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_sent < byte_stream.size() || pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d bytes (%0d directed, then %0d random files), %0d results.",
                 bytes_sent, N_DIRECTED, files_built, results_seen);
        $display("By status: parsing %0d, complete %0d, not wave %0d, not pcm %0d, early %0d.",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4]);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ wav_header_parser_unit.f @@
hdl/wavhp_pkg.sv
hdl/wavhp_in_stage.sv
hdl/wavhp_core.sv
hdl/wav_header_parser_unit.sv
tb/tb.sv
